[src/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, one of them disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define U8D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same check, but also active while reset is high.
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[src/u8d_pkg.sv]
// -----------------------------------------------------------------------------
// UTF-8 decoder package
// Field widths, status codes, transfer structs and the lead byte decode.
// -----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int CP_WIDTH    = 31;
   localparam int COUNT_WIDTH = 3;
   localparam int CONT_BITS   = 6;
   localparam int LEAD_BITS   = 7;

   localparam logic [COUNT_WIDTH-1:0] MAX_PENDING = 3'd5;
   localparam logic [CP_WIDTH-1:0]    SURR_LOW    = 31'h0000_D800;
   localparam logic [CP_WIDTH-1:0]    SURR_HIGH   = 31'h0000_DFFF;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_LEAD,
      STATUS_TRUNCATED,
      STATUS_SURROGATE
   } status_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_in;
      logic                  last_byte;
   } item_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      status_type          status;
      logic                ends_string;
   } result_type;

   typedef struct packed {
      logic                   ok;
      logic [COUNT_WIDTH-1:0] extra;
      logic [LEAD_BITS-1:0]   bits;
   } lead_type;

   // Classify a lead byte by its run of leading ones.
   function automatic lead_type lead_decode(input logic [BYTE_WIDTH-1:0] b);
      lead_type r;
      r = '0;
      r.ok = 1'b1;
      unique casez (b)
         8'b0???????: begin
            r.extra = 3'd0;
            r.bits  = b[6:0];
         end
         8'b110?????: begin
            r.extra = 3'd1;
            r.bits  = {2'b00, b[4:0]};
         end
         8'b1110????: begin
            r.extra = 3'd2;
            r.bits  = {3'b000, b[3:0]};
         end
         8'b11110???: begin
            r.extra = 3'd3;
            r.bits  = {4'b0000, b[2:0]};
         end
         8'b111110??: begin
            r.extra = 3'd4;
            r.bits  = {5'b00000, b[1:0]};
         end
         8'b1111110?: begin
            r.extra = 3'd5;
            r.bits  = {6'b000000, b[0]};
         end
         default: begin
            r.ok = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

[src/utf8_to_codepoint_decoder_top.sv]
// Decodes a UTF-8 byte stream, one byte per request transfer, into code points
// of up to 31 bits, with 1- to 6-byte sequences and overlong forms accepted.
// The block takes one byte every cycle while the result register can take a
// result. A result is formed as its final byte passes from the input register
// through the decode into the result register. That rate is set by the decode
// and state update loop on the sequence state.
// Errors (bad lead byte, truncated string, surrogate value) give a single
// result with a zero code point that ends the string; bytes up to the one
// marked last are then dropped without results.
// -----------------------------------------------------------------------------
// UTF-8 to code point decoder, top level
// Input register, decode core and result register with valid/ready channels.
// -----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [u8d_pkg::BYTE_WIDTH-1:0] req_byte_in,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8d_pkg::CP_WIDTH-1:0]  rsp_code_point,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_ends_string
);

   logic                item_valid;
   u8d_pkg::item_type   item;
   logic                slot_free;
   logic                advance;
   logic                result_valid;
   u8d_pkg::result_type result;

   // A byte leaves the input register only when a result could be stored.
   assign advance = item_valid && slot_free;

   u8d_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   u8d_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   u8d_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (result_valid),
      .result          (result),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_ends_string (rsp_ends_string)
   );

endmodule

[src/u8d_in_stage.sv]
// -----------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one request byte and its last flag ahead of the decode logic.
// -----------------------------------------------------------------------------
module u8d_in_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [u8d_pkg::BYTE_WIDTH-1:0]    req_byte_in,
   input  logic                              req_last_byte,
   input  logic                              advance,
   output logic                              item_valid,
   output u8d_pkg::item_type                 item
);

   logic              valid_ff;
   logic              valid_in;
   u8d_pkg::item_type item_ff;

   // The register refills in the same cycle that its item moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.byte_in   <= req_byte_in;
         item_ff.last_byte <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[src/u8d_core.sv]
// -----------------------------------------------------------------------------
// UTF-8 decoder core
// Sequence state and the combinational decode of one byte into a result.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  u8d_pkg::item_type   item,
   output logic                result_valid,
   output u8d_pkg::result_type result
);

   logic [u8d_pkg::COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic [u8d_pkg::CP_WIDTH-1:0]    acc_ff, acc_in;
   logic                            skip_ff, skip_in;

   u8d_pkg::lead_type               lead;
   logic [u8d_pkg::COUNT_WIDTH-1:0] pending_dec;
   logic [u8d_pkg::CP_WIDTH-1:0]    cont_cp;
   logic                            emit;
   logic [u8d_pkg::CP_WIDTH-1:0]    emit_cp;
   u8d_pkg::status_type             emit_status;

   assign lead        = u8d_pkg::lead_decode(item.byte_in);
   assign pending_dec = pending_ff - 3'd1;
   assign cont_cp     = {acc_ff[u8d_pkg::CP_WIDTH-u8d_pkg::CONT_BITS-1:0],
                         item.byte_in[u8d_pkg::CONT_BITS-1:0]};

   // Decide whether this byte finishes a result, and with what status.
   always_comb begin
      emit        = 1'b0;
      emit_cp     = '0;
      emit_status = u8d_pkg::STATUS_OK;
      pending_in  = pending_ff;
      acc_in      = acc_ff;
      skip_in     = skip_ff;
      priority if (skip_ff) begin
         if (item.last_byte) begin
            skip_in = 1'b0;
         end
         pending_in = '0;
         acc_in     = '0;
      end else if (pending_ff == '0) begin
         priority if (!lead.ok) begin
            emit        = 1'b1;
            emit_status = u8d_pkg::STATUS_BAD_LEAD;
         end else if (lead.extra == '0) begin
            emit    = 1'b1;
            emit_cp = {24'd0, lead.bits};
         end else if (item.last_byte) begin
            emit        = 1'b1;
            emit_status = u8d_pkg::STATUS_TRUNCATED;
         end else begin
            pending_in = lead.extra;
            acc_in     = {24'd0, lead.bits};
         end
      end else if (pending_dec != '0) begin
         if (item.last_byte) begin
            emit        = 1'b1;
            emit_status = u8d_pkg::STATUS_TRUNCATED;
         end else begin
            pending_in = pending_dec;
            acc_in     = cont_cp;
         end
      end else begin
         emit = 1'b1;
         if (cont_cp >= u8d_pkg::SURR_LOW && cont_cp <= u8d_pkg::SURR_HIGH) begin
            emit_status = u8d_pkg::STATUS_SURROGATE;
         end else begin
            emit_cp = cont_cp;
         end
      end
      // Every result starts the next sequence from scratch.
      if (emit) begin
         pending_in = '0;
         acc_in     = '0;
         skip_in    = (emit_status != u8d_pkg::STATUS_OK) && !item.last_byte;
      end
   end

   always_comb begin
      result_valid       = fire && emit;
      result.code_point  = emit_cp;
      result.status      = emit_status;
      result.ends_string = (emit_status != u8d_pkg::STATUS_OK) || item.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         acc_ff     <= '0;
         skip_ff    <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         skip_ff    <= skip_in;
      end
   end

   `U8D_ASSERT(a_pending_range, pending_ff <= u8d_pkg::MAX_PENDING, "pending count out of range")
   `U8D_ASSERT(a_skip_clean, skip_ff |-> (pending_ff == '0 && acc_ff == '0), "state kept while skipping")
   `U8D_ASSERT(a_err_result, (result_valid && result.status != u8d_pkg::STATUS_OK) |-> (result.code_point == '0 && result.ends_string), "error result not clean")
   `U8D_ASSERT(a_last_resets, (fire && item.last_byte) |=> (!skip_ff && pending_ff == '0), "string end left state behind")

endmodule

[src/u8d_out_stage.sv]
// -----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Result register that holds one decoded result until it is taken.
// -----------------------------------------------------------------------------
module u8d_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  u8d_pkg::result_type              result,
   output logic                             slot_free,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [u8d_pkg::CP_WIDTH-1:0]     rsp_code_point,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_ends_string
);

   logic                valid_ff;
   logic                valid_in;
   u8d_pkg::result_type result_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = result_ff.code_point;
   assign rsp_status      = result_ff.status;
   assign rsp_ends_string = result_ff.ends_string;

endmodule

[tb/testbench.sv]
// -----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Streams directed and random UTF-8 strings into the decoder with random
// idling on both channels and checks every result against a local decoder.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 800;
   localparam int QUIET_TAIL   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE       = 8;

   typedef struct {
      logic [7:0] value;
      logic       last;
      bit         hold_for_drain;
   } stream_byte_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_byte_in = '0;
   logic                         req_last_byte = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [u8d_pkg::CP_WIDTH-1:0] rsp_code_point;
   logic [1:0]                   rsp_status;
   logic                         rsp_ends_string;

   stream_byte_type     byte_stream[$];
   u8d_pkg::result_type expected_points[$];

   // Local copy of the decoder state.
   logic [2:0]                   cont_left = '0;
   logic [u8d_pkg::CP_WIDTH-1:0] partial_point = '0;
   logic                         skip_to_end = 1'b0;

   int mismatches = 0;
   int send_gap = 0;
   int recv_stall = 0;
   int quiet_cycles = 0;

   utf8_to_codepoint_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_ends_string (rsp_ends_string)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Idling is allowed in two of every three stretches and never near the end.
   function automatic bit idle_ok();
      return byte_stream.size() > QUIET_TAIL && (byte_stream.size() / 120) % 3 != 1;
   endfunction

   task automatic post_result(input logic [u8d_pkg::CP_WIDTH-1:0] point,
                              input u8d_pkg::status_type st, input logic last);
      u8d_pkg::result_type r;
      r.code_point  = (st == u8d_pkg::STATUS_OK) ? point : '0;
      r.status      = st;
      r.ends_string = (st != u8d_pkg::STATUS_OK) || last;
      expected_points.push_back(r);
      cont_left     = '0;
      partial_point = '0;
      if (st != u8d_pkg::STATUS_OK && !last) skip_to_end = 1'b1;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      int                           ones;
      logic [u8d_pkg::CP_WIDTH-1:0] next_point;
      ones = 0;
      if (skip_to_end) begin
         if (last) skip_to_end = 1'b0;
         cont_left     = '0;
         partial_point = '0;
      end else if (cont_left == 0) begin
         while (ones < 8 && b[7-ones]) ones++;
         if (ones == 0) begin
            post_result({24'b0, b[6:0]}, u8d_pkg::STATUS_OK, last);
         end else if (ones == 1 || ones > 6) begin
            post_result('0, u8d_pkg::STATUS_BAD_LEAD, last);
         end else if (last) begin
            post_result('0, u8d_pkg::STATUS_TRUNCATED, last);
         end else begin
            cont_left     = 3'(ones - 1);
            partial_point = {23'b0, b & (8'hFF >> (ones + 1))};
         end
      end else begin
         // The two prefix bits of a continuation byte are ignored.
         next_point = {partial_point[u8d_pkg::CP_WIDTH-7:0], b[5:0]};
         cont_left  = cont_left - 3'd1;
         if (cont_left != 0) begin
            if (last) post_result('0, u8d_pkg::STATUS_TRUNCATED, last);
            else partial_point = next_point;
         end else if (next_point >= u8d_pkg::SURR_LOW && next_point <= u8d_pkg::SURR_HIGH) begin
            post_result('0, u8d_pkg::STATUS_SURROGATE, last);
         end else begin
            post_result(next_point, u8d_pkg::STATUS_OK, last);
         end
      end
   endtask

   task automatic add_byte(input logic [7:0] value, input logic last,
                           input bit hold_for_drain = 1'b0);
      stream_byte_type s;
      s.value          = value;
      s.last           = last;
      s.hold_for_drain = hold_for_drain;
      byte_stream.push_back(s);
   endtask

   // One string of random characters; a broken string is cut short at a
   // random byte, which then carries the last flag.
   task automatic add_string(input bit broken, input bit hold_for_drain);
      logic [7:0] seq[$];
      logic [7:0] lead;
      int         nchars, len, pick, cut;
      nchars = $urandom_range(1, 6);
      for (int k = 0; k < nchars; k++) begin
         pick = $urandom_range(0, 9);
         len  = (pick < 4) ? 1 : (pick < 6) ? 2 : pick - 3;
         if (len == 1) begin
            lead = 8'($urandom_range(0, 127));
         end else begin
            lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
         end
         if (len == 3 && $urandom_range(0, 4) == 0) begin
            // Aim at the surrogate range.
            seq.push_back(8'hED);
            seq.push_back({2'b10, 1'b1, 5'($urandom)});
            seq.push_back({2'b10, 6'($urandom)});
         end else begin
            seq.push_back(lead);
            for (int j = 1; j < len; j++) begin
               if ($urandom_range(0, 15) == 0) seq.push_back(8'($urandom));
               else seq.push_back({2'b10, 6'($urandom)});
            end
         end
      end
      cut = broken ? $urandom_range(0, seq.size() - 1) : seq.size() - 1;
      for (int i = 0; i <= cut; i++) begin
         add_byte(seq[i], i == cut, hold_for_drain && i == 0);
      end
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t: %s", $realtime, msg);
   endtask

   // Request driver.
   always @(posedge clock) begin
      stream_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_byte_in, req_last_byte);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_stream.size() != 0 &&
                         !(byte_stream[0].hold_for_drain && expected_points.size() != 0)) begin
               next_byte = byte_stream.pop_front();
               req_valid     <= 1'b1;
               req_byte_in   <= next_byte.value;
               req_last_byte <= next_byte.last;
               if (idle_ok() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and ready control.
   always @(posedge clock) begin
      u8d_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               note_mismatch($sformatf("result with none pending: code_point %h status %0d ends %b",
                                       rsp_code_point, rsp_status, rsp_ends_string));
            end else begin
               want = expected_points.pop_front();
               if (rsp_code_point !== want.code_point)
                  note_mismatch($sformatf("code_point: expected %h, got %h",
                                          want.code_point, rsp_code_point));
               if (rsp_status !== want.status)
                  note_mismatch($sformatf("status: expected %s, got %0d",
                                          want.status.name(), rsp_status));
               if (rsp_ends_string !== want.ends_string)
                  note_mismatch($sformatf("ends_string: expected %b, got %b",
                                          want.ends_string, rsp_ends_string));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
            recv_stall = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick, directed;
      // Plain ASCII at both ends of the range.
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b1);
      // Six-byte sequence giving the largest code point, with varied prefixes.
      add_byte(8'hFD, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'hBF, 1'b0);
      add_byte(8'h3F, 1'b1);
      // Five-byte form of code point 0x200000.
      add_byte(8'hF8, 1'b0);
      add_byte(8'h88, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      // Surrogate in mid-string, then the rest of the string is dropped.
      add_byte(8'hED, 1'b0);
      add_byte(8'hA0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h41, 1'b1);
      // Bad lead byte on the final byte: nothing is dropped afterwards.
      add_byte(8'hFF, 1'b1);
      // Stray continuation byte, then a dropped byte that ends the string.
      add_byte(8'h80, 1'b0);
      add_byte(8'hFE, 1'b1);
      // Lead byte marked last, a string that ends mid-sequence, a lone bad lead byte and a two-byte character.
      add_byte(8'hC3, 1'b1);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b1);
      add_byte(8'hFE, 1'b1);
      add_byte(8'hC2, 1'b0);
      add_byte(8'hA9, 1'b1);
      directed = byte_stream.size();

      // The first random string waits for the directed results to drain.
      add_string(1'b0, 1'b1);
      while (byte_stream.size() < directed + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            add_string(1'b0, pick < 2);
         end else if (pick < 88) begin
            add_string(1'b1, 1'b0);
         end else begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom), $urandom_range(0, 2) == 0);
         end
      end
      // Close any string that random noise left open.
      add_byte(8'h20, 1'b1);

      while (byte_stream.size() != 0 || req_valid) @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
